FILE: sv/fdab_pkg.sv
// ----------------------------------------------------------------------------
// Farbfeld decoder package
// Payload types, result codes, register indexes and the file magic that are
// shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package fdab_pkg;

  // Result kinds carried in result_kind.
  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_PIXEL     = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_BG_RED   = 2'd0;
  localparam logic [1:0] REG_BG_GREEN = 2'd1;
  localparam logic [1:0] REG_BG_BLUE  = 2'd2;

  // The eight bytes of the ASCII string "farbfeld".
  localparam logic [7:0] MAGIC [8] = '{8'h66, 8'h61, 8'h72, 8'h62,
                                       8'h66, 8'h65, 8'h6c, 8'h64};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic [7:0] wr_data;
  } cfg_item_t;

endpackage

FILE: sv/fdab_chan_if.sv
// ----------------------------------------------------------------------------
// Farbfeld decoder channel
// Valid/ready channel with a payload of configurable type.
// ----------------------------------------------------------------------------
interface fdab_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

FILE: sv/farbfeld_decode_alpha_blend.sv
// ----------------------------------------------------------------------------
// Farbfeld decoder with alpha blend
// Parses a farbfeld byte stream and blends each pixel over a background color.
// ----------------------------------------------------------------------------
// The block takes one byte of a farbfeld file per transaction on in_i and can
// take a new byte in every clock cycle while out_o does not stall. A byte is
// parsed from the input register once the output register can take its
// result, and any result it causes is loaded into the output register. The
// rate is set by the output register: the parser moves whenever that
// register is empty or being drained, so a stall on out_o backs up into in_i
// once a result waits and the input register holds the next byte.
// A byte with start_of_file set restarts the parser at any point. After the
// 16-byte header one header result gives width and height; every eighth byte
// of pixel data then gives one blended RGB888 pixel result, computed as
// (fg*a + bg*(255-a)) >> 8 from the high byte of each channel. A bad magic
// gives one error result and the block waits for the next start of file.
// Bytes past the final pixel, and bytes before the first start, are dropped.
// The background registers on cfg_i should only be written while idle.
// ----------------------------------------------------------------------------
module farbfeld_decode_alpha_blend
  import fdab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fdab_chan_if.sink   in_i,
  fdab_chan_if.sink   cfg_i,
  fdab_chan_if.source out_o
);

  // Parser modes, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_HEADER = 4'b0010,
    MODE_PIXELS = 4'b0100,
    MODE_IGNORE = 4'b1000
  } mode_e;

  // Blend of one channel. The sum is at most 255*255, so it fits 16 bits.
  function automatic logic [7:0] blend(input logic [7:0] fg, input logic [7:0] bg,
                                       input logic [7:0] a);
    logic [15:0] sum;
    sum = 16'(fg) * 16'(a) + 16'(bg) * (16'd255 - 16'(a));
    return sum[15:8];
  endfunction

  // Background color registers, written over the configuration channel.
  logic [7:0] bg_red_q, bg_green_q, bg_blue_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_red_q   <= '0;
      bg_green_q <= '0;
      bg_blue_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        REG_BG_RED:   bg_red_q   <= cfg_i.data.wr_data;
        REG_BG_GREEN: bg_green_q <= cfg_i.data.wr_data;
        REG_BG_BLUE:  bg_blue_q  <= cfg_i.data.wr_data;
        default: ;
      endcase
    end
  end

  // Input register. The parser advances whenever the output register can
  // take whatever result the parsed byte produces.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_sof_q;
  logic       out_valid_q;
  out_item_t  out_data_q;
  logic       advance;
  logic       parse_en;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign parse_en   = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data.data_byte;
      in_sof_q  <= in_i.data.start_of_file;
    end
  end

  // Parser state.
  mode_e       mode_q, mode_d;
  logic [3:0]  phase_q, phase_d;
  logic        mismatch_q, mismatch_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [31:0] col_q, col_d;
  logic [31:0] row_q, row_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic [7:0]  blue_q, blue_d;

  // Parse step for the byte in the input register.
  mode_e       eff_mode;
  logic [3:0]  eff_phase;
  logic        eff_mismatch;
  logic [31:0] eff_width;
  logic [31:0] eff_height;
  logic        mismatch_now;
  logic        is_last;
  logic [31:0] col_next;
  logic        res_valid;
  out_item_t   res;

  always_comb begin
    // A start of file restarts the header parse with this byte as magic byte 0.
    if (in_sof_q) begin
      eff_mode     = MODE_HEADER;
      eff_phase    = '0;
      eff_mismatch = 1'b0;
      eff_width    = '0;
      eff_height   = '0;
    end else begin
      eff_mode     = mode_q;
      eff_phase    = phase_q;
      eff_mismatch = mismatch_q;
      eff_width    = width_q;
      eff_height   = height_q;
    end

    mode_d     = eff_mode;
    phase_d    = eff_phase;
    mismatch_d = eff_mismatch;
    width_d    = eff_width;
    height_d   = eff_height;
    col_d      = col_q;
    row_d      = row_q;
    red_d      = red_q;
    green_d    = green_q;
    blue_d     = blue_q;
    res_valid  = 1'b0;
    res        = '0;

    mismatch_now = eff_mismatch || (in_byte_q != MAGIC[eff_phase[2:0]]);
    is_last      = (row_q == height_q - 32'd1) && (col_q == width_q - 32'd1);
    col_next     = col_q + 32'd1;

    unique case (eff_mode)
      MODE_HEADER: begin
        phase_d = eff_phase + 4'd1;
        if (!eff_phase[3]) begin
          mismatch_d = mismatch_now;
          if (eff_phase[2:0] == 3'd7 && mismatch_now) begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_BAD_MAGIC;
            mode_d           = MODE_IGNORE;
            phase_d          = '0;
          end
        end else if (!eff_phase[2]) begin
          width_d = {eff_width[23:0], in_byte_q};
        end else begin
          height_d = {eff_height[23:0], in_byte_q};
        end
        if (eff_phase == 4'd15) begin
          res_valid        = 1'b1;
          res.result_kind  = KIND_HEADER;
          res.image_width  = width_d;
          res.image_height = height_d;
          res.last_pixel   = (width_d == '0) || (height_d == '0);
          mode_d           = res.last_pixel ? MODE_IGNORE : MODE_PIXELS;
          phase_d          = '0;
          col_d            = '0;
          row_d            = '0;
        end
      end
      MODE_PIXELS: begin
        phase_d = {1'b0, eff_phase[2:0] + 3'd1};
        unique case (eff_phase[2:0])
          3'd0: red_d   = in_byte_q;
          3'd2: green_d = in_byte_q;
          3'd4: blue_d  = in_byte_q;
          3'd6: begin
            // The high alpha byte is here; the low alpha byte, like every low byte, is dropped.
            red_d   = blend(red_q, bg_red_q, in_byte_q);
            green_d = blend(green_q, bg_green_q, in_byte_q);
            blue_d  = blend(blue_q, bg_blue_q, in_byte_q);
          end
          3'd7: begin
            res_valid       = 1'b1;
            res.result_kind = KIND_PIXEL;
            res.pixel_red   = red_q;
            res.pixel_green = green_q;
            res.pixel_blue  = blue_q;
            res.last_pixel  = is_last;
            phase_d         = '0;
            if (col_next == width_q) begin
              col_d = '0;
              row_d = row_q + 32'd1;
            end else begin
              col_d = col_next;
            end
            if (is_last) begin
              mode_d = MODE_IGNORE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      phase_q    <= '0;
      mismatch_q <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      col_q      <= '0;
      row_q      <= '0;
      red_q      <= '0;
      green_q    <= '0;
      blue_q     <= '0;
    end else if (parse_en) begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      mismatch_q <= mismatch_d;
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      red_q      <= red_d;
      green_q    <= green_d;
      blue_q     <= blue_d;
    end
  end

  // Output register. A new result can load in the same cycle the old one
  // leaves, so results can go out back to back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (parse_en && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (parse_en && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

FILE: sv/fdab_checker.sv
// ----------------------------------------------------------------------------
// Farbfeld decoder checker
// Port-level assertions on the result channel, bound to the decoder.
// ----------------------------------------------------------------------------
module fdab_checker
  import fdab_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result that is stalled stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Pixel results carry no header dimensions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.result_kind == KIND_PIXEL |->
      out_data.image_width == '0 && out_data.image_height == '0)
    else $error("pixel result with nonzero dimensions");

  // Header results carry no color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.result_kind == KIND_HEADER |->
      out_data.pixel_red == '0 && out_data.pixel_green == '0 &&
      out_data.pixel_blue == '0)
    else $error("header result with nonzero color");

  // An empty image is flagged as last on its header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.result_kind == KIND_HEADER &&
      (out_data.image_width == '0 || out_data.image_height == '0) |->
      out_data.last_pixel)
    else $error("empty image header without last flag");

  // Error results are bare.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.result_kind == KIND_BAD_MAGIC |->
      out_data.image_width == '0 && out_data.image_height == '0 &&
      !out_data.last_pixel && out_data.pixel_red == '0)
    else $error("bad magic result with payload");

endmodule

bind farbfeld_decode_alpha_blend fdab_checker u_fdab_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
